[rtl/mcmf_pkg.sv]
// Shared constants, record layouts and sequencer codes for the min-cost max-flow engine.
// Used by every module of the block but mcmf_ram; depends on nothing.
package mcmf_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int VALUE_BITS  = 16;

    localparam int ARC_SLOTS   = 2 * MAX_EDGES;
    localparam int NODE_DEPTH  = MAX_NODES + 1;
    localparam int NODE_W      = 11;
    localparam int NADDR_W     = $clog2(NODE_DEPTH);
    localparam int ARC_W       = $clog2(ARC_SLOTS);
    localparam int LINK_W      = ARC_W + 1;
    localparam int CNT_W       = ARC_W + 1;
    localparam int VAL_W       = VALUE_BITS;
    localparam int COST_W      = VALUE_BITS + 1;
    localparam int DIST_W      = 32;
    localparam int FLOW_W      = 28;
    localparam int TOTAL_W     = 48;
    localparam int IDX_W       = 2;
    localparam int OP_W        = 5;

    localparam logic [LINK_W-1:0]        NO_ARC   = '1;
    localparam logic signed [DIST_W-1:0] FAR_AWAY = 32'sd2000000010;
    localparam logic [FLOW_W-1:0]        FLOW_MAX = '1;
    localparam logic [TOTAL_W-1:0]       COST_MAX = '1;

    localparam logic [IDX_W-1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE     = 2'd1;
    localparam logic [IDX_W-1:0] REG_SINK       = 2'd2;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op S_CLEAR   = 5'd0;
    localparam t_op S_IDLE    = 5'd1;
    localparam t_op S_RD_U    = 5'd2;
    localparam t_op S_WR_U    = 5'd3;
    localparam t_op S_RD_V    = 5'd4;
    localparam t_op S_WR_V    = 5'd5;
    localparam t_op S_SOLVE   = 5'd6;
    localparam t_op S_INIT    = 5'd7;
    localparam t_op S_SEED    = 5'd8;
    localparam t_op S_POP     = 5'd9;
    localparam t_op S_DEQ     = 5'd10;
    localparam t_op S_HEAD    = 5'd11;
    localparam t_op S_ARC     = 5'd12;
    localparam t_op S_TEST    = 5'd13;
    localparam t_op S_RELAX   = 5'd14;
    localparam t_op S_CHK_RD  = 5'd15;
    localparam t_op S_CHK     = 5'd16;
    localparam t_op S_W1A     = 5'd17;
    localparam t_op S_W1B     = 5'd18;
    localparam t_op S_W1C     = 5'd19;
    localparam t_op S_PUSHCHK = 5'd20;
    localparam t_op S_W2A     = 5'd21;
    localparam t_op S_W2B     = 5'd22;
    localparam t_op S_W2C     = 5'd23;
    localparam t_op S_W2D     = 5'd24;
    localparam t_op S_ACC     = 5'd25;
    localparam t_op S_ACC2    = 5'd26;
    localparam t_op S_FINISH  = 5'd27;

    typedef struct packed {
        logic                     queued;
        logic [LINK_W-1:0]        pred;
        logic signed [DIST_W-1:0] distance;
    } t_node_rec;

    typedef struct packed {
        logic [NODE_W-1:0]        tail;
        logic [NODE_W-1:0]        head;
        logic signed [COST_W-1:0] cost;
        logic [LINK_W-1:0]        link;
    } t_arc_rec;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_cmd;

    typedef struct packed {
        logic edge_ok;
        logic edge_fits;
        logic last;
        logic params_bad;
        logic sweep_last;
        logic clear_last;
        logic queue_empty;
        logic arc_none;
        logic arc_skip;
        logic unreachable;
        logic walk_go;
        logic push_bad;
        logic out_busy;
    } t_status;

endpackage

[rtl/min_cost_max_flow_engine.sv]
// Top level of the min-cost max-flow engine (successive shortest paths over SPFA).
// Depends on mcmf_pkg, mcmf_ctrl, mcmf_datapath and, through it, mcmf_ram.
//
// Edges are sent as requests on the input channel; each stored edge is accepted
// and then takes two read-then-write updates of the adjacency list head store
// before the next request is taken, while an edge that is dropped is only checked.
// The request with last_edge set starts the solve, whose length depends on the
// graph: every search first sweeps the node store, then dequeues nodes and scans
// their arcs, and an augmenting path is walked once to find its bottleneck and
// once more to update residuals, followed by accumulation. One result follows,
// after which a clearing pass over all 1025 head store entries empties the
// adjacency lists; the same pass runs after reset. No edge is taken during a solve
// or a clearing pass, while configuration writes are always taken. The result
// waits in an output register, so edges of the next graph are taken while it is
// pending.
module min_cost_max_flow_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mcmf_pkg::NODE_W-1:0]   i_from_node,
    input  logic [mcmf_pkg::NODE_W-1:0]   i_to_node,
    input  logic [15:0]                   i_capacity,
    input  logic [15:0]                   i_unit_cost,
    input  logic                          i_last_edge,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mcmf_pkg::FLOW_W-1:0]   o_max_flow,
    output logic [mcmf_pkg::TOTAL_W-1:0]  o_min_cost,
    output logic                          o_edge_overflow,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mcmf_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [mcmf_pkg::NODE_W-1:0]   i_cfg_data
);
    import mcmf_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The sequencer owns the input handshake; the datapath owns the result register.
    mcmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    mcmf_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_from_node     (i_from_node),
        .i_to_node       (i_to_node),
        .i_capacity      (i_capacity),
        .i_unit_cost     (i_unit_cost),
        .i_last_edge     (i_last_edge),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_max_flow      (o_max_flow),
        .o_min_cost      (o_min_cost),
        .o_edge_overflow (o_edge_overflow)
    );

    // Register writes are accepted in every cycle.
    assign o_cfg_ready = 1'b1;

endmodule

[rtl/mcmf_ram.sv]
// Generic single-port RAM with registered read data.
// Stand-alone; used for every store of the engine.
module mcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mcmf_ctrl.sv]
// Sequencer of the min-cost max-flow engine: loading, search, path walks and clearing.
// Depends on mcmf_pkg; drives mcmf_datapath through command and status structs.
module mcmf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  mcmf_pkg::t_status i_status,
    output logic             o_in_ready,
    output mcmf_pkg::t_cmd   o_cmd
);
    import mcmf_pkg::*;

    t_op r_state;
    t_op n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (i_status.clear_last) n_state = S_IDLE;
            S_IDLE:    if (i_in_valid) n_state = S_RD_U;
            S_RD_U: begin
                if (i_status.edge_ok && i_status.edge_fits) n_state = S_WR_U;
                else if (i_status.last)                     n_state = S_SOLVE;
                else                                        n_state = S_IDLE;
            end
            S_WR_U:    n_state = S_RD_V;
            S_RD_V:    n_state = S_WR_V;
            S_WR_V:    n_state = i_status.last ? S_SOLVE : S_IDLE;
            S_SOLVE:   n_state = i_status.params_bad ? S_FINISH : S_INIT;
            S_INIT:    if (i_status.sweep_last) n_state = S_SEED;
            S_SEED:    n_state = S_POP;
            S_POP:     n_state = i_status.queue_empty ? S_CHK_RD : S_DEQ;
            S_DEQ:     n_state = S_HEAD;
            S_HEAD:    n_state = S_ARC;
            S_ARC:     n_state = i_status.arc_none ? S_POP : S_TEST;
            S_TEST:    n_state = i_status.arc_skip ? S_ARC : S_RELAX;
            S_RELAX:   n_state = S_ARC;
            S_CHK_RD:  n_state = S_CHK;
            S_CHK:     n_state = i_status.unreachable ? S_FINISH : S_W1A;
            S_W1A:     n_state = i_status.walk_go ? S_W1B : S_PUSHCHK;
            S_W1B:     n_state = S_W1C;
            S_W1C:     n_state = S_W1A;
            S_PUSHCHK: n_state = i_status.push_bad ? S_FINISH : S_W2A;
            S_W2A:     n_state = i_status.walk_go ? S_W2B : S_ACC;
            S_W2B:     n_state = S_W2C;
            S_W2C:     n_state = S_W2D;
            S_W2D:     n_state = S_W2A;
            S_ACC:     n_state = S_ACC2;
            S_ACC2:    n_state = S_INIT;
            S_FINISH:  if (!i_status.out_busy) n_state = S_CLEAR;
            default:   n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.op     = r_state;
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_RD_U))
        else $error("accepted request did not start loading");
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_status.clear_last) |=> (r_state == S_IDLE))
        else $error("clearing pass did not return to idle");
    a_finish_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && i_status.out_busy) |=> (r_state == S_FINISH))
        else $error("result dropped while output register was busy");
`endif

endmodule

[rtl/mcmf_datapath.sv]
// Datapath of the min-cost max-flow engine: stores, queue, registers and arithmetic.
// Depends on mcmf_pkg and mcmf_ram; executes the commands of mcmf_ctrl.
module mcmf_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mcmf_pkg::t_cmd                i_cmd,
    input  logic [mcmf_pkg::NODE_W-1:0]   i_from_node,
    input  logic [mcmf_pkg::NODE_W-1:0]   i_to_node,
    input  logic [15:0]                   i_capacity,
    input  logic [15:0]                   i_unit_cost,
    input  logic                          i_last_edge,
    input  logic                          i_cfg_valid,
    input  logic [mcmf_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [mcmf_pkg::NODE_W-1:0]   i_cfg_data,
    input  logic                          i_out_ready,
    output mcmf_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output logic [mcmf_pkg::FLOW_W-1:0]   o_max_flow,
    output logic [mcmf_pkg::TOTAL_W-1:0]  o_min_cost,
    output logic                          o_edge_overflow
);
    import mcmf_pkg::*;

    // Configuration and latched edge.
    logic [NODE_W-1:0]  r_node_count, r_source, r_sink;
    logic [NODE_W-1:0]  r_u, r_v;
    logic [VAL_W-1:0]   r_cap, r_ucost;
    logic               r_last;
    logic [CNT_W-1:0]   r_arc_count;
    logic               r_overflow;

    // Solve registers.
    logic [NADDR_W-1:0]       r_idx;
    logic [NADDR_W-1:0]       r_qh;
    logic [NADDR_W-1:0]       r_qn;
    logic [NODE_W-1:0]        r_cur;
    logic signed [DIST_W-1:0] r_cur_dist;
    logic [LINK_W-1:0]        r_arc, r_link, r_dst_pred;
    logic [NODE_W-1:0]        r_x, r_tail;
    logic signed [COST_W-1:0] r_cost;
    logic signed [DIST_W-1:0] r_dst_dist;
    logic [VAL_W-1:0]         r_push;
    logic                     r_push_none;
    logic [NODE_W-1:0]        r_steps;
    logic [FLOW_W-1:0]        r_flow;
    logic [TOTAL_W-1:0]       r_total;
    logic [TOTAL_W-1:0]       r_prod;

    logic                     r_out_valid;
    logic [FLOW_W-1:0]        r_out_flow;
    logic [TOTAL_W-1:0]       r_out_cost;
    logic                     r_out_ovf;

    // Memory ports.
    logic                 node_we, first_we, arc_we, res_we, queue_we;
    logic [NADDR_W-1:0]   node_addr, first_addr, queue_addr;
    logic [ARC_W-1:0]     arc_addr, res_addr;
    t_node_rec            node_wdata, node_rd;
    logic [LINK_W-1:0]    first_wdata, first_rd;
    t_arc_rec             arc_wdata, arc_rd;
    logic [VAL_W-1:0]     res_wdata, res_rd;
    logic [NODE_W-1:0]    queue_wdata, queue_rd;

    // Derived values.
    logic [NODE_W-1:0]        nc;
    logic [NADDR_W-1:0]       qh_inc;
    logic [NADDR_W:0]         qsum;
    logic [NADDR_W-1:0]       q_tail;
    logic signed [DIST_W:0]   nd;
    logic                     relax_less, enq;
    logic signed [COST_W-1:0] fwd_cost;
    logic [CNT_W:0]           cnt_plus2;
    logic [ARC_W-1:0]         cnt_lo;
    logic                     out_busy;
    logic [FLOW_W:0]          flow_sum;
    logic [TOTAL_W:0]         total_sum;
    logic [DIST_W-2:0]        d_pos;

    assign nc        = (r_node_count > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : r_node_count;
    assign qh_inc    = (r_qh == NADDR_W'(NODE_DEPTH - 1)) ? '0 : r_qh + 1'b1;
    assign qsum      = {1'b0, r_qh} + {1'b0, r_qn};
    assign q_tail    = (qsum >= (NADDR_W + 1)'(NODE_DEPTH)) ?
                       NADDR_W'(qsum - (NADDR_W + 1)'(NODE_DEPTH)) : qsum[NADDR_W-1:0];
    assign nd        = {r_cur_dist[DIST_W-1], r_cur_dist} +
                       (DIST_W + 1)'(r_cost);
    assign relax_less = nd < $signed({node_rd.distance[DIST_W-1], node_rd.distance});
    assign enq       = !node_rd.queued && (r_qn <= NADDR_W'(MAX_NODES));
    assign fwd_cost  = $signed({1'b0, r_ucost});
    assign cnt_plus2 = {1'b0, r_arc_count} + (CNT_W + 1)'(2);
    assign cnt_lo    = r_arc_count[ARC_W-1:0];
    assign out_busy  = r_out_valid && !i_out_ready;
    assign flow_sum  = {1'b0, r_flow} + (FLOW_W + 1)'(r_push);
    assign total_sum = {1'b0, r_total} + {1'b0, r_prod};
    assign d_pos     = (r_dst_dist > 0) ? r_dst_dist[DIST_W-2:0] : '0;

    // Memory address and write selection per command.
    always_comb begin
        node_we     = 1'b0;
        first_we    = 1'b0;
        arc_we      = 1'b0;
        res_we      = 1'b0;
        queue_we    = 1'b0;
        node_addr   = r_idx;
        first_addr  = r_idx;
        queue_addr  = r_qh;
        arc_addr    = r_arc[ARC_W-1:0];
        res_addr    = r_arc[ARC_W-1:0];
        node_wdata  = '{queued: 1'b0, pred: NO_ARC, distance: FAR_AWAY};
        first_wdata = NO_ARC;
        arc_wdata   = '{tail: r_u, head: r_v, cost: fwd_cost, link: first_rd};
        res_wdata   = r_cap;
        queue_wdata = r_source;
        unique case (i_cmd.op)
            S_CLEAR: begin
                first_we = 1'b1;
            end
            S_RD_U: begin
                first_addr = r_u[NADDR_W-1:0];
            end
            S_WR_U: begin
                first_addr  = r_u[NADDR_W-1:0];
                first_we    = 1'b1;
                first_wdata = LINK_W'(r_arc_count);
                arc_addr    = cnt_lo;
                arc_we      = 1'b1;
                res_addr    = cnt_lo;
                res_we      = 1'b1;
            end
            S_RD_V: begin
                first_addr = r_v[NADDR_W-1:0];
            end
            S_WR_V: begin
                first_addr  = r_v[NADDR_W-1:0];
                first_we    = 1'b1;
                first_wdata = LINK_W'(r_arc_count) + 1'b1;
                arc_addr    = cnt_lo | ARC_W'(1);
                arc_we      = 1'b1;
                arc_wdata   = '{tail: r_v, head: r_u, cost: -fwd_cost, link: first_rd};
                res_addr    = cnt_lo | ARC_W'(1);
                res_we      = 1'b1;
                res_wdata   = '0;
            end
            S_INIT: begin
                node_we = 1'b1;
            end
            S_SEED: begin
                node_addr  = r_source[NADDR_W-1:0];
                node_we    = 1'b1;
                node_wdata = '{queued: 1'b1, pred: NO_ARC, distance: '0};
                queue_addr = '0;
                queue_we   = 1'b1;
            end
            S_DEQ: begin
                node_addr  = queue_rd[NADDR_W-1:0];
                first_addr = queue_rd[NADDR_W-1:0];
            end
            S_HEAD: begin
                node_addr  = r_cur[NADDR_W-1:0];
                node_we    = 1'b1;
                node_wdata = '{queued: 1'b0, pred: node_rd.pred, distance: node_rd.distance};
            end
            S_TEST: begin
                node_addr = arc_rd.head[NADDR_W-1:0];
            end
            S_RELAX: begin
                node_addr   = r_x[NADDR_W-1:0];
                node_we     = relax_less;
                node_wdata  = '{queued: node_rd.queued | enq, pred: r_arc,
                                distance: nd[DIST_W-1:0]};
                queue_addr  = q_tail;
                queue_we    = relax_less && enq;
                queue_wdata = r_x;
            end
            S_CHK_RD: begin
                node_addr = r_sink[NADDR_W-1:0];
            end
            S_W1B: begin
                node_addr = arc_rd.tail[NADDR_W-1:0];
            end
            S_W2B: begin
                res_we    = 1'b1;
                res_wdata = res_rd - r_push;
            end
            S_W2C: begin
                res_addr  = r_arc[ARC_W-1:0] ^ ARC_W'(1);
                node_addr = r_tail[NADDR_W-1:0];
            end
            S_W2D: begin
                res_addr  = r_arc[ARC_W-1:0] ^ ARC_W'(1);
                res_we    = 1'b1;
                res_wdata = res_rd + r_push;
            end
            default: begin
            end
        endcase
    end

    mcmf_ram #(.WIDTH($bits(t_node_rec)), .DEPTH(NODE_DEPTH)) u_node_ram (
        .i_clk(i_clk), .i_we(node_we), .i_addr(node_addr),
        .i_wdata(node_wdata), .o_rdata(node_rd)
    );
    mcmf_ram #(.WIDTH(LINK_W), .DEPTH(NODE_DEPTH)) u_first_ram (
        .i_clk(i_clk), .i_we(first_we), .i_addr(first_addr),
        .i_wdata(first_wdata), .o_rdata(first_rd)
    );
    mcmf_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_queue_ram (
        .i_clk(i_clk), .i_we(queue_we), .i_addr(queue_addr),
        .i_wdata(queue_wdata), .o_rdata(queue_rd)
    );
    mcmf_ram #(.WIDTH($bits(t_arc_rec)), .DEPTH(ARC_SLOTS)) u_arc_ram (
        .i_clk(i_clk), .i_we(arc_we), .i_addr(arc_addr),
        .i_wdata(arc_wdata), .o_rdata(arc_rd)
    );
    mcmf_ram #(.WIDTH(VAL_W), .DEPTH(ARC_SLOTS)) u_res_ram (
        .i_clk(i_clk), .i_we(res_we), .i_addr(res_addr),
        .i_wdata(res_wdata), .o_rdata(res_rd)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_W'(1);
            r_source     <= NODE_W'(1);
            r_sink       <= NODE_W'(1);
            r_arc_count  <= '0;
            r_overflow   <= 1'b0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_NODE_COUNT: r_node_count <= i_cfg_data;
                    REG_SOURCE:     r_source     <= i_cfg_data;
                    REG_SINK:       r_sink       <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op) inside
                S_CLEAR, S_INIT: r_idx <= r_idx + 1'b1;
                S_RD_U: begin
                    if (o_status.edge_ok && !o_status.edge_fits) r_overflow <= 1'b1;
                end
                S_WR_V:  r_arc_count <= cnt_plus2[CNT_W-1:0];
                S_SOLVE, S_ACC2: r_idx <= NADDR_W'(1);
                S_FINISH: begin
                    if (!out_busy) begin
                        r_out_valid <= 1'b1;
                        r_idx       <= '0;
                        r_arc_count <= '0;
                        r_overflow  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload and solve registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op) inside
            S_IDLE: begin
                if (i_cmd.accept) begin
                    r_u     <= i_from_node;
                    r_v     <= i_to_node;
                    r_cap   <= i_capacity[VAL_W-1:0];
                    r_ucost <= i_unit_cost[VAL_W-1:0];
                    r_last  <= i_last_edge;
                end
            end
            S_SOLVE: begin
                r_flow  <= '0;
                r_total <= '0;
            end
            S_SEED: begin
                r_qh <= '0;
                r_qn <= NADDR_W'(1);
            end
            S_DEQ: begin
                r_cur <= queue_rd;
                r_qh  <= qh_inc;
                r_qn  <= r_qn - 1'b1;
            end
            S_HEAD: begin
                r_cur_dist <= node_rd.distance;
                r_arc      <= first_rd;
            end
            S_TEST: begin
                if (o_status.arc_skip) begin
                    r_arc <= arc_rd.link;
                end
                r_x    <= arc_rd.head;
                r_link <= arc_rd.link;
                r_cost <= arc_rd.cost;
            end
            S_RELAX: begin
                if (relax_less && enq) r_qn <= r_qn + 1'b1;
                r_arc <= r_link;
            end
            S_CHK: begin
                r_dst_dist  <= node_rd.distance;
                r_dst_pred  <= node_rd.pred;
                r_arc       <= node_rd.pred;
                r_push      <= '0;
                r_push_none <= 1'b1;
                r_steps     <= '0;
            end
            S_W1B: begin
                if (r_push_none || res_rd < r_push) begin
                    r_push      <= res_rd;
                    r_push_none <= 1'b0;
                end
            end
            S_W1C, S_W2D: begin
                r_arc   <= node_rd.pred;
                r_steps <= r_steps + 1'b1;
            end
            S_PUSHCHK: begin
                r_arc   <= r_dst_pred;
                r_steps <= '0;
            end
            S_W2B: r_tail <= arc_rd.tail;
            S_ACC: begin
                r_flow <= flow_sum[FLOW_W] ? FLOW_MAX : flow_sum[FLOW_W-1:0];
                r_prod <= TOTAL_W'(d_pos * r_push);
            end
            S_ACC2: r_total <= total_sum[TOTAL_W] ? COST_MAX : total_sum[TOTAL_W-1:0];
            S_FINISH: begin
                if (!out_busy) begin
                    r_out_flow <= r_flow;
                    r_out_cost <= r_total;
                    r_out_ovf  <= r_overflow;
                end
            end
            default: begin
            end
        endcase
    end

    // Status back to the sequencer.
    assign o_status.edge_ok    = (r_u != '0) && (r_u <= NODE_W'(MAX_NODES)) &&
                                 (r_v != '0) && (r_v <= NODE_W'(MAX_NODES));
    assign o_status.edge_fits  = cnt_plus2 <= (CNT_W + 1)'(ARC_SLOTS);
    assign o_status.last       = r_last;
    assign o_status.params_bad = (r_source == '0) || (r_source > nc) || (r_sink == '0) ||
                                 (r_sink > nc) || (r_source == r_sink);
    assign o_status.sweep_last = (r_idx == nc[NADDR_W-1:0]);
    assign o_status.clear_last = (r_idx == NADDR_W'(NODE_DEPTH - 1));
    assign o_status.queue_empty = (r_qn == '0);
    assign o_status.arc_none   = (r_arc == NO_ARC);
    assign o_status.arc_skip   = (arc_rd.head == '0) || (arc_rd.head > nc) || (res_rd == '0);
    assign o_status.unreachable = (node_rd.distance == FAR_AWAY);
    assign o_status.walk_go    = (r_arc != NO_ARC) && (r_steps <= nc);
    assign o_status.push_bad   = r_push_none || (r_push == '0);
    assign o_status.out_busy   = out_busy;

    assign o_out_valid     = r_out_valid;
    assign o_max_flow      = r_out_flow;
    assign o_min_cost      = r_out_cost;
    assign o_edge_overflow = r_out_ovf;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qn <= NADDR_W'(NODE_DEPTH))
        else $error("work queue holds more nodes than it has entries");
    a_arc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_arc_count[0] && (r_arc_count <= CNT_W'(ARC_SLOTS)))
        else $error("arc count is odd or beyond the arc store");
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && i_cmd.op != S_FINISH) |=> !r_out_valid)
        else $error("result was taken but stayed valid");
`endif

endmodule
